// File: rtl/core/utf16_to_utf8_transcoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent checks, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define U2U_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define U2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types, constants and byte-forming functions of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int unsigned CP_W = 21;

    // Top six bits of a high and of a low surrogate
    localparam logic [5:0] HI_TAG = 6'b110110;
    localparam logic [5:0] LO_TAG = 6'b110111;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Sequence length minus one: 0..3 for one to four bytes
    typedef logic [1:0] t_len;

    // One queued job: one or two code points and the string's final flag
    typedef struct packed {
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
        logic            two;
        logic            fin;
    } t_job;

    // Push side of the job queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Pop side of the job queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    // Encoded length of a code point
    function automatic t_len cp_len(input logic [CP_W-1:0] cp);
        t_len len;
        if (cp < 21'h80) begin
            len = 2'd0;
        end else if (cp < 21'h800) begin
            len = 2'd1;
        end else if (cp < SUPP_BASE) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    // Byte at position idx of the UTF-8 sequence of cp
    function automatic logic [7:0] cp_byte(input logic [CP_W-1:0] cp,
                                           input t_len len,
                                           input t_len idx);
        logic [7:0] b;
        t_len       rem;
        rem = len - idx;
        if (idx == 2'd0) begin
            case (len)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            case (rem)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

// File: rtl/core/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streams UTF-16 code units in and UTF-8 bytes out, pairing surrogates.
// ----------------------------------------------------------------------------
// One code unit is taken per cycle while the job queue has room. The output
// side gives one byte per cycle while the sink takes them. An item produces
// no bytes for a held high surrogate, 1 to 4 for an ordinary unit or a pair,
// up to 6 when a held surrogate is flushed as three bytes ahead of the new
// unit. The single output byte register sets this pace; P_DEPTH jobs of queue
// let the input run ahead of it. When the block is idle, an accepted item
// passes the queue, the job registers and the output register before its
// first byte shows. Unpaired surrogates come out as three-byte sequences.
// tuser carries run_end (last byte caused by an input word); tlast marks the
// last byte of the string.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] code_unit
    input  logic        i_s_tlast,   // final_unit
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [0:0]  o_m_tuser,   // [0] run_end
    output logic        o_m_tlast    // string_end
);

    u2u_pkg::t_push push;
    u2u_pkg::t_head head;
    logic           full;
    logic           pop;

    // Classify units and keep the held surrogate
    u2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_unit  (i_s_tdata),
        .i_fin   (i_s_tlast),
        .i_full  (full),
        .o_push  (push)
    );

    // Buffer jobs between the two sides
    u2u_queue #(
        .P_DEPTH (P_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Serialize code points into bytes
    u2u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_run_end (o_m_tuser[0]),
        .o_str_end (o_m_tlast)
    );

endmodule

// File: rtl/core/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Accepts code units, tracks a held high surrogate and pushes code point jobs.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u2u_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_unit,
    input  logic           i_fin,
    input  logic           i_full,
    output u2u_pkg::t_push o_push
);

    logic       r_pend;
    logic [9:0] r_hb;
    logic       n_pend;
    logic [9:0] n_hb;

    logic                      accept;
    logic                      is_hi;
    logic                      is_lo;
    logic                      hold_new;
    logic [u2u_pkg::CP_W-1:0]  unit_cp;
    logic [u2u_pkg::CP_W-1:0]  pair_cp;
    logic [u2u_pkg::CP_W-1:0]  held_cp;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Classify the unit
    assign is_hi    = (i_unit[15:10] == u2u_pkg::HI_TAG);
    assign is_lo    = (i_unit[15:10] == u2u_pkg::LO_TAG);
    assign hold_new = is_hi && !i_fin;
    assign unit_cp  = {5'd0, i_unit};
    assign held_cp  = {5'd0, u2u_pkg::HI_TAG, r_hb};
    assign pair_cp  = u2u_pkg::SUPP_BASE + {1'b0, r_hb, i_unit[9:0]};

    // Form the job and the next held state
    always_comb begin
        o_push.valid   = 1'b0;
        o_push.job.cp0 = unit_cp;
        o_push.job.cp1 = unit_cp;
        o_push.job.two = 1'b0;
        o_push.job.fin = i_fin;
        n_pend         = r_pend;
        n_hb           = r_hb;
        if (accept) begin
            n_pend = 1'b0;
            n_hb   = 10'd0;
            if (r_pend) begin
                o_push.valid = 1'b1;
                if (is_lo) begin
                    o_push.job.cp0 = pair_cp;
                end else begin
                    o_push.job.cp0 = held_cp;
                    if (hold_new) begin
                        n_pend = 1'b1;
                        n_hb   = i_unit[9:0];
                    end else begin
                        o_push.job.two = 1'b1;
                    end
                end
            end else if (hold_new) begin
                n_pend = 1'b1;
                n_hb   = i_unit[9:0];
            end else begin
                o_push.valid = 1'b1;
            end
        end
    end

    // Hold the pending surrogate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hb   <= 10'd0;
        end else begin
            r_pend <= n_pend;
            r_hb   <= n_hb;
        end
    end

    `U2U_ASSERT_NEXT(a_fin_clears_pend, i_clk, i_rst_n, accept && i_fin, !r_pend, "final unit left a surrogate held")
    `U2U_ASSERT_NOW(a_final_pushes, i_clk, i_rst_n, accept && i_fin, o_push.valid, "final unit pushed no job")

endmodule

// File: rtl/core/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Short job queue between the classifying front and the byte-emitting back.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u2u_queue #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  u2u_pkg::t_push i_push,
    output logic           o_full,
    output u2u_pkg::t_head o_head,
    input  logic           i_pop
);

    localparam int unsigned AW = $clog2(P_DEPTH);
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    u2u_pkg::t_job r_mem [P_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_count == CW'(P_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Write the job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `U2U_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push.valid, "job pushed into a full queue")
    `U2U_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(P_DEPTH), "queue count beyond depth")

endmodule

// File: rtl/core/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Pops code point jobs and emits their UTF-8 bytes, one word per cycle while the sink takes them.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u2u_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  u2u_pkg::t_head i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_run_end,
    output logic           o_str_end
);

    logic                     r_act;
    logic [u2u_pkg::CP_W-1:0] r_cp;
    logic [u2u_pkg::CP_W-1:0] r_next;
    logic                     r_has_next;
    logic                     r_fin;
    u2u_pkg::t_len            r_len;
    u2u_pkg::t_len            r_idx;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_run;
    logic       r_out_str;

    logic slot_free;
    logic emit;
    logic last_byte;
    logic job_done;

    assign slot_free = !r_out_valid || i_ready;
    assign emit      = r_act && slot_free;
    assign last_byte = (r_idx == r_len);
    assign job_done  = emit && last_byte && !r_has_next;
    assign o_pop     = i_head.valid && (!r_act || job_done);

    // Walk the bytes of the current job and load the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_has_next <= 1'b0;
            r_idx      <= 2'd0;
        end else begin
            if (o_pop) begin
                r_act      <= 1'b1;
                r_cp       <= i_head.job.cp0;
                r_len      <= u2u_pkg::cp_len(i_head.job.cp0);
                r_idx      <= 2'd0;
                r_next     <= i_head.job.cp1;
                r_has_next <= i_head.job.two;
                r_fin      <= i_head.job.fin;
            end else if (emit) begin
                if (!last_byte) begin
                    r_idx <= r_idx + 2'd1;
                end else if (r_has_next) begin
                    r_cp       <= r_next;
                    r_len      <= u2u_pkg::cp_len(r_next);
                    r_idx      <= 2'd0;
                    r_has_next <= 1'b0;
                end else begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    // Output register: load a word or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= u2u_pkg::cp_byte(r_cp, r_len, r_idx);
            r_out_run   <= last_byte && !r_has_next;
            r_out_str   <= last_byte && !r_has_next && r_fin;
        end else if (slot_free) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_byte    = r_out_byte;
    assign o_run_end = r_out_run;
    assign o_str_end = r_out_str;

    `U2U_ASSERT_NOW(a_str_implies_run, i_clk, i_rst_n, r_out_valid && r_out_str, r_out_run, "string end on a word that does not end its run")
    `U2U_ASSERT_NOW(a_idx_in_len, i_clk, i_rst_n, r_act, r_idx <= r_len, "byte index past sequence length")

endmodule
